### hw/rtl/kdar_pkg.sv
package kdar_pkg;

    // Request kinds carried in s_tuser
    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,  // update with a new raw sample
        REQ_HOLD   = 2'd1,  // update, raw level unchanged
        REQ_CLEAR  = 2'd2,  // drop the sticky event flags
        REQ_NOP    = 2'd3   // report only
    } req_t;

    // Configuration register indexes
    localparam logic [1:0] REG_DEBOUNCE_TIME      = 2'd0;
    localparam logic [1:0] REG_FIRST_REPEAT_DELAY = 2'd1;
    localparam logic [1:0] REG_REPEAT_INTERVAL    = 2'd2;

    localparam int CFG_WIDTH  = 16;
    localparam int STAMP_WIDTH = 32;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_TIME_RST      = 16'd20;
    localparam logic [CFG_WIDTH-1:0] FIRST_REPEAT_DELAY_RST = 16'd500;
    localparam logic [CFG_WIDTH-1:0] REPEAT_INTERVAL_RST    = 16'd100;

    // Sticky event flag positions
    localparam int FLAG_DOWN   = 0;
    localparam int FLAG_UP     = 1;
    localparam int FLAG_PRESS  = 2;
    localparam int FLAG_REPEAT = 3;

    // One key sample as it sits in the input register
    typedef struct packed {
        req_t                   req_type;
        logic [STAMP_WIDTH-1:0] now_time;
        logic                   raw_pressed;
    } key_item_t;

    // Reported status; key_held is the lowest bit
    typedef struct packed {
        logic stable_level;
        logic repeat_flag;
        logic press_flag;
        logic up_flag;
        logic down_flag;
        logic key_held;
    } key_result_t;

    // Configuration write
    typedef struct packed {
        logic                 wr_en;
        logic [1:0]           addr;
        logic [CFG_WIDTH-1:0] wr_data;
    } cfg_write_t;

endpackage

### hw/rtl/kdar_core.sv
module kdar_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  kdar_pkg::cfg_write_t cfg,
    input  logic                 step,
    input  kdar_pkg::key_item_t  item,
    output kdar_pkg::key_result_t result
);
    import kdar_pkg::*;

    // Configuration registers
    logic [CFG_WIDTH-1:0] debounce_time_reg;
    logic [CFG_WIDTH-1:0] first_repeat_delay_reg;
    logic [CFG_WIDTH-1:0] repeat_interval_reg;

    // Key state
    logic                  raw_level_reg, raw_level_next;
    logic                  debounced_reg, debounced_next;
    logic                  held_reg, held_next;
    logic [TIME_WIDTH-1:0] last_change_reg, last_change_next;
    logic [TIME_WIDTH-1:0] next_repeat_reg, next_repeat_next;
    logic [3:0]            flags_reg, flags_next;

    logic [63:0]           now_wide;
    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] elapsed;
    logic [TIME_WIDTH-1:0] to_deadline;
    logic                  level;
    logic                  deadline_hit;

    // Timestamp taken modulo 2^TIME_WIDTH
    assign now_wide = 64'(item.now_time);
    assign now_t    = now_wide[TIME_WIDTH-1:0];

    // Configuration writes; index 3 is ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_time_reg      <= DEBOUNCE_TIME_RST;
            first_repeat_delay_reg <= FIRST_REPEAT_DELAY_RST;
            repeat_interval_reg    <= REPEAT_INTERVAL_RST;
        end else if (cfg.wr_en) begin
            case (cfg.addr)
                REG_DEBOUNCE_TIME:      debounce_time_reg      <= cfg.wr_data;
                REG_FIRST_REPEAT_DELAY: first_repeat_delay_reg <= cfg.wr_data;
                REG_REPEAT_INTERVAL:    repeat_interval_reg    <= cfg.wr_data;
                default: ;
            endcase
        end
    end

    // Debounce and repeat update for one item
    always_comb begin
        level            = (item.req_type == REQ_SAMPLE) ? item.raw_pressed : raw_level_reg;
        raw_level_next   = raw_level_reg;
        debounced_next   = debounced_reg;
        held_next        = held_reg;
        last_change_next = last_change_reg;
        next_repeat_next = next_repeat_reg;
        flags_next       = flags_reg;

        // raw change restarts the debounce timer
        last_change_next = (level != raw_level_reg) ? now_t : last_change_reg;
        elapsed          = now_t - last_change_next;
        to_deadline      = now_t - next_repeat_reg;
        deadline_hit     = !to_deadline[TIME_WIDTH-1];

        case (item.req_type)
            REQ_CLEAR: begin
                last_change_next = last_change_reg;
                flags_next       = 4'd0;
            end
            REQ_SAMPLE, REQ_HOLD: begin
                raw_level_next = level;
                if (64'(elapsed) >= 64'(debounce_time_reg)) begin
                    debounced_next = level;
                end
                if (debounced_next) begin
                    if (!held_reg) begin
                        held_next                = 1'b1;
                        next_repeat_next         = now_t
                                                 + TIME_WIDTH'(first_repeat_delay_reg);
                        flags_next[FLAG_DOWN]    = 1'b1;
                        flags_next[FLAG_PRESS]   = 1'b1;
                    end else if (deadline_hit) begin
                        next_repeat_next         = now_t
                                                 + TIME_WIDTH'(repeat_interval_reg);
                        flags_next[FLAG_REPEAT]  = 1'b1;
                        flags_next[FLAG_PRESS]   = 1'b1;
                    end
                end else if (held_reg) begin
                    held_next            = 1'b0;
                    next_repeat_next     = '0;
                    flags_next[FLAG_UP]  = 1'b1;
                end
            end
            default: begin
                last_change_next = last_change_reg;
            end
        endcase
    end

    // State registers advance once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_level_reg   <= 1'b0;
            debounced_reg   <= 1'b0;
            held_reg        <= 1'b0;
            last_change_reg <= '0;
            next_repeat_reg <= '0;
            flags_reg       <= 4'd0;
        end else if (step) begin
            raw_level_reg   <= raw_level_next;
            debounced_reg   <= debounced_next;
            held_reg        <= held_next;
            last_change_reg <= last_change_next;
            next_repeat_reg <= next_repeat_next;
            flags_reg       <= flags_next;
        end
    end

    // Status after this item is applied
    assign result.key_held     = held_next;
    assign result.down_flag    = flags_next[FLAG_DOWN];
    assign result.up_flag      = flags_next[FLAG_UP];
    assign result.press_flag   = flags_next[FLAG_PRESS];
    assign result.repeat_flag  = flags_next[FLAG_REPEAT];
    assign result.stable_level = debounced_next;

endmodule

### hw/rtl/key_debounce_autorepeat.sv
// Key debouncer with typematic auto-repeat. Each input transfer carries a request kind
// in s_tuser (0 new raw sample, 1 update keeping the last raw level, 2 clear the sticky
// flags, 3 report only) and a timestamp plus raw level in s_tdata; every transfer gives
// exactly one status transfer on m_tdata with the state after that item. An item is
// captured in an input register; once the output register is free or m_tready is high,
// the debounce and repeat logic updates the key state and loads the output register.
// One item is taken every cycle while m_tready is high. Timestamps wrap modulo
// 2^TIME_WIDTH and the repeat deadline uses a wrap-safe signed difference. The user
// must write configuration (debounce time, first repeat delay, repeat interval) via
// cfg_wr_en/cfg_addr/cfg_wr_data only while idle; the block does not enforce this.
module key_debounce_autorepeat #(
    parameter int TIME_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] now_time, [32] raw_pressed, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] key_held, [1] down_flag, [2] up_flag,
                                   // [3] press_flag, [4] repeat_flag, [5] stable_level
);
    import kdar_pkg::*;

    logic        in_valid_reg;
    key_item_t   in_item_reg;
    logic        out_valid_reg;
    key_result_t out_result_reg;
    key_result_t core_result;
    cfg_write_t  cfg;
    logic        advance;

    assign cfg.wr_en   = cfg_wr_en;
    assign cfg.addr    = cfg_addr;
    assign cfg.wr_data = cfg_wr_data;

    // item moves from input register to output register when the output frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.req_type    <= req_t'(s_tuser);
            in_item_reg.now_time    <= s_tdata[STAMP_WIDTH-1:0];
            in_item_reg.raw_pressed <= s_tdata[STAMP_WIDTH];
        end
    end

    kdar_core #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (advance),
        .item    (in_item_reg),
        .result  (core_result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_result_reg};

endmodule
